>>> rtl/core/dqvp_pkg.sv
// Package for the dq voltage to phase voltage transform.
// Holds word types, configuration types, the quarter-wave sine ROM and shared arithmetic helpers.
`default_nettype none

package dqvp_pkg;

  localparam int SineTableEntries = 256;
  localparam int SineIdxW         = $clog2(SineTableEntries + 1);
  localparam int SineProdW        = 14 + SineIdxW;
  localparam int Q15One           = 32767;
  localparam int Sqrt3Scaled      = 56753;
  localparam int DivStages        = 16;

  localparam logic [14:0] PoleResetVal   = 15'd7;
  localparam logic [14:0] SupplyResetVal = 15'd3072;
  localparam logic [14:0] LimitResetVal  = 15'd1536;

  // Polynomial coefficients for sin(x), x in Q30 of a quarter turn
  localparam logic [63:0] Pc1 = 64'd1686629713;
  localparam logic [63:0] Pc3 = 64'd693598668;
  localparam logic [63:0] Pc5 = 64'd85569306;
  localparam logic [63:0] Pc7 = 64'd5026990;
  localparam logic [63:0] Pc9 = 64'd172271;

  typedef enum logic [1:0] {
    RegPolePairs   = 2'd0,
    RegSupply      = 2'd1,
    RegLimit       = 2'd2,
    RegInvert      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] target_d_volts;
    logic signed [15:0] target_q_volts;
    logic        [15:0] mech_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] phase_a;
    logic signed [15:0] phase_b;
    logic signed [15:0] phase_c;
    logic        [15:0] elec_angle;
  } out_word_t;

  // supply is already forced to at least one
  typedef struct packed {
    logic [7:0]  pole_pairs;
    logic [14:0] supply;
    logic [14:0] limit;
    logic        invert;
  } cfg_t;

  typedef struct packed {
    logic               neg_d;
    logic               neg_q;
    logic               ovf_d;
    logic               ovf_q;
    logic signed [15:0] sin;
    logic signed [15:0] cos;
    logic        [15:0] eang;
  } side_t;

  typedef struct packed {
    logic [29:0] rem_d;
    logic [29:0] rem_q;
    logic [15:0] quo_d;
    logic [15:0] quo_q;
    side_t       side;
  } div_word_t;

  typedef logic [14:0] sine_rom_t [SineTableEntries + 1];

  function automatic sine_rom_t gen_sine_rom();
    sine_rom_t   rom;
    logic [63:0] p, p2, p3, p5, p7, p9, s, q;
    for (int i = 0; i <= SineTableEntries; i++) begin
      p  = (64'(i) << 30) / 64'(SineTableEntries);
      p2 = (p * p) >> 30;
      p3 = (p2 * p) >> 30;
      p5 = (p3 * p2) >> 30;
      p7 = (p5 * p2) >> 30;
      p9 = (p7 * p2) >> 30;
      s  = ((Pc1 * p) >> 30) - ((Pc3 * p3) >> 30) + ((Pc5 * p5) >> 30)
         - ((Pc7 * p7) >> 30) + ((Pc9 * p9) >> 30);
      q  = (s * 64'(Q15One) + (64'd1 << 29)) >> 30;
      rom[i] = (q > 64'(Q15One)) ? 15'(Q15One) : q[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = gen_sine_rom();

  // Truncating divide by 32767 for magnitudes below 2^31:
  // m = q0*32768 + lo = q0*32767 + (q0 + lo), then fix up the small remainder
  function automatic logic [17:0] div_q15one(logic [31:0] m);
    logic [17:0] q0;
    logic [17:0] r;
    q0 = {1'b0, m[31:15]};
    r  = q0 + {3'd0, m[14:0]};
    return q0 + 18'(r >= 18'(Q15One)) + 18'(r >= 18'(2 * Q15One))
              + 18'(r >= 18'(3 * Q15One));
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [33:0] v);
    if (v > 34'sd32767) begin
      return 16'sh7fff;
    end else if (v < -34'sd32768) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dq_voltage_to_phase_voltages_top.sv
// Top level of the dq voltage to phase voltage transform: configuration registers and stall control.
// Instantiates dqvp_front, dqvp_div and dqvp_rotate; depends on dqvp_pkg.
`default_nettype none

// Takes d/q voltage targets (Q8.8 volts) and a mechanical angle, and returns three Q15 phase
// voltages plus the electrical angle. Fully pipelined: one word is accepted every cycle unless
// the output is held, and each word passes the front end, the 16-stage divider that scales the
// targets by the supply voltage (one quotient bit a stage) and the back end. The whole
// pipeline holds while a finished word waits at the output, so in_ready_o follows out_ready_i
// whenever the output register is full. Configuration registers: 0 pole pairs, 1 supply
// voltage, 2 voltage limit, 3 direction invert; write them only with the pipeline empty.

module dq_voltage_to_phase_voltages_top import dqvp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_word_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_word_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire cfg_reg_e    cfg_idx_i,
  input  wire logic [14:0] cfg_data_i
);

  logic [7:0]  pole_pairs_q;
  logic [14:0] supply_q;
  logic [14:0] limit_q;
  logic        invert_q;
  cfg_t        cfg;
  logic        en;
  logic        front_valid, div_valid;
  div_word_t   front_word, div_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_pairs_q <= PoleResetVal[7:0];
      supply_q     <= SupplyResetVal;
      limit_q      <= LimitResetVal;
      invert_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPolePairs: pole_pairs_q <= cfg_data_i[7:0];
        RegSupply:    supply_q     <= cfg_data_i;
        RegLimit:     limit_q      <= cfg_data_i;
        RegInvert:    invert_q     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // a zero supply divides as one
  always_comb begin
    cfg.pole_pairs = pole_pairs_q;
    cfg.supply     = (supply_q == '0) ? 15'd1 : supply_q;
    cfg.limit      = limit_q;
    cfg.invert     = invert_q;
  end

  // advance everything unless the output word is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  dqvp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_data_i),
    .cfg_i   (cfg),
    .valid_o (front_valid),
    .word_o  (front_word)
  );

  dqvp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (front_valid),
    .word_i   (front_word),
    .supply_i (cfg.supply),
    .valid_o  (div_valid),
    .word_o   (div_word)
  );

  dqvp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .word_i  (div_word),
    .valid_o (out_valid_o),
    .word_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/dqvp_front.sv
// Front end: clamp and magnitude of the d/q targets, electrical angle, sine/cosine ROM reads.
// Two register stages; output feeds the divider. Depends on dqvp_pkg.
`default_nettype none

module dqvp_front import dqvp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire in_word_t  word_i,
  input  wire cfg_t      cfg_i,
  output logic           valid_o,
  output div_word_t      word_o
);

  function automatic logic signed [15:0] sine_of(logic [15:0] ang);
    logic [SineProdW-1:0] prod;
    logic [SineIdxW-1:0]  idx;
    logic [SineIdxW-1:0]  sel;
    logic [14:0]          mag;
    prod = SineProdW'(ang[13:0]) * SineProdW'(SineTableEntries);
    idx  = prod[SineProdW-1:14];
    sel  = ang[14] ? (SineIdxW'(SineTableEntries) - idx) : idx;
    mag  = SineRom[sel];
    return ang[15] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  endfunction

  // magnitude of the clamped target, times 32767
  function automatic logic [29:0] scaled_mag(logic signed [15:0] v,
                                             logic [14:0] lim);
    logic signed [15:0] lim_s;
    logic signed [15:0] vc;
    logic signed [15:0] a;
    lim_s = signed'({1'b0, lim});
    if (v > lim_s) begin
      vc = lim_s;
    end else if (v < -lim_s) begin
      vc = -lim_s;
    end else begin
      vc = v;
    end
    a = vc[15] ? -vc : vc;
    return {a[14:0], 15'd0} - {15'd0, a[14:0]};
  endfunction

  logic              s1_valid_q;
  logic [29:0]       n_d_q, n_q_q;
  logic              neg_d_q, neg_q_q;
  logic [15:0]       eang_q;
  logic [23:0]       eang_prod;
  logic [30:0]       ovf_bound;
  logic [15:0]       cos_ang;
  logic              valid_q;
  div_word_t         word_d, word_q;

  assign eang_prod = 24'(word_i.mech_angle) * 24'(cfg_i.pole_pairs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      valid_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_d_q   <= scaled_mag(word_i.target_d_volts, cfg_i.limit);
      n_q_q   <= scaled_mag(word_i.target_q_volts, cfg_i.limit);
      neg_d_q <= word_i.target_d_volts[15] ^ cfg_i.invert;
      neg_q_q <= word_i.target_q_volts[15] ^ cfg_i.invert;
      eang_q  <= eang_prod[15:0];
      word_q  <= word_d;
    end
  end

  // quotient above 32768 saturates whatever the sign: n >= 32769 * supply
  assign ovf_bound = (31'(cfg_i.supply) << 15) + 31'(cfg_i.supply);
  assign cos_ang   = eang_q + 16'd16384;

  always_comb begin
    word_d            = '0;
    word_d.rem_d      = n_d_q;
    word_d.rem_q      = n_q_q;
    word_d.side.neg_d = neg_d_q;
    word_d.side.neg_q = neg_q_q;
    word_d.side.ovf_d = {1'b0, n_d_q} >= ovf_bound;
    word_d.side.ovf_q = {1'b0, n_q_q} >= ovf_bound;
    word_d.side.sin   = sine_of(eang_q);
    word_d.side.cos   = sine_of(cos_ang);
    word_d.side.eang  = eang_q;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

>>> rtl/core/dqvp_div.sv
// Pipelined restoring divider: one quotient bit per stage for both the d and q lanes.
// Carries the angle and sign sideband alongside. Depends on dqvp_pkg.
`default_nettype none

module dqvp_div import dqvp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire div_word_t  word_i,
  input  wire logic [14:0] supply_i,
  output logic            valid_o,
  output div_word_t       word_o
);

  div_word_t stage_q [DivStages];
  logic      valid_q [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    localparam int Sh = DivStages - 1 - k;
    div_word_t   src, nxt;
    logic        src_valid;
    logic [30:0] dsh;

    if (k == 0) begin : g_first
      assign src       = word_i;
      assign src_valid = valid_i;
    end else begin : g_next
      assign src       = stage_q[k-1];
      assign src_valid = valid_q[k-1];
    end

    assign dsh = 31'(supply_i) << Sh;

    always_comb begin
      nxt = src;
      if ({1'b0, src.rem_d} >= dsh) begin
        nxt.rem_d     = src.rem_d - dsh[29:0];
        nxt.quo_d[Sh] = 1'b1;
      end
      if ({1'b0, src.rem_q} >= dsh) begin
        nxt.rem_q     = src.rem_q - dsh[29:0];
        nxt.quo_q[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= nxt;
      end
    end
  end

  assign valid_o = valid_q[DivStages-1];
  assign word_o  = stage_q[DivStages-1];

endmodule

`default_nettype wire

>>> rtl/core/dqvp_rotate.sv
// Back end: signed scaled voltages, inverse Park, inverse Clarke and the output register.
// Eight register stages. Depends on dqvp_pkg.
`default_nettype none

module dqvp_rotate import dqvp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire div_word_t word_i,
  output logic           valid_o,
  output out_word_t      word_o
);

  function automatic logic signed [15:0] signed_u(logic [15:0] quo, logic neg,
                                                  logic ovf);
    logic signed [33:0] v;
    if (ovf) begin
      v = neg ? -34'sd32768 : 34'sd32767;
    end else begin
      v = neg ? -signed'(34'(quo)) : signed'(34'(quo));
    end
    return sat16(v);
  endfunction

  logic [7:0] valid_q;

  // stage 0: scaled voltages
  logic signed [15:0] ud_q, uq_q, sin0_q, cos0_q;
  logic [15:0]        eang0_q;
  // stage 1: products
  logic signed [31:0] p_cd_q, p_sq_q, p_sd_q, p_cq_q;
  logic [15:0]        eang1_q;
  // stage 2: alpha/beta numerators as sign and magnitude
  logic signed [32:0] sa, sb;
  logic [32:0]        na, nb;
  logic [31:0]        ma_q, mb_q;
  logic               sga_q, sgb_q;
  logic [15:0]        eang2_q;
  // stage 3: alpha, beta
  logic signed [15:0] alpha3_q, beta3_q;
  logic [15:0]        eang3_q;
  // stage 4: sqrt3 * beta magnitude
  logic [16:0]        babs;
  logic [32:0]        tprod;
  logic [31:0]        mt_q;
  logic               sgt_q;
  logic signed [15:0] alpha4_q;
  logic [15:0]        eang4_q;
  // stage 5: twice phase b before halving
  logic [17:0]        tq;
  logic signed [18:0] t5;
  logic signed [19:0] x5_q;
  logic signed [15:0] alpha5_q;
  logic [15:0]        eang5_q;
  // stage 6: phase a and b
  logic signed [19:0] xr;
  logic signed [19:0] xh;
  logic signed [15:0] pa6_q, pb6_q;
  logic [15:0]        eang6_q;
  // stage 7: output register
  out_word_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[6:0], valid_i};
    end
  end

  always_comb begin
    sa    = 33'(p_cd_q) - 33'(p_sq_q);
    sb    = 33'(p_sd_q) + 33'(p_cq_q);
    na    = -sa;
    nb    = -sb;
    babs  = beta3_q[15] ? 17'(-signed'(17'(beta3_q))) : 17'(beta3_q);
    tprod = 33'(babs) * 33'(Sqrt3Scaled);
    tq    = div_q15one(mt_q);
    t5    = sgt_q ? -signed'(19'(tq)) : signed'(19'(tq));
    // halve with truncation toward zero
    xr    = x5_q + signed'(20'(x5_q[19]));
    xh    = xr >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ud_q    <= signed_u(word_i.quo_d, word_i.side.neg_d, word_i.side.ovf_d);
      uq_q    <= signed_u(word_i.quo_q, word_i.side.neg_q, word_i.side.ovf_q);
      sin0_q  <= word_i.side.sin;
      cos0_q  <= word_i.side.cos;
      eang0_q <= word_i.side.eang;

      p_cd_q  <= cos0_q * ud_q;
      p_sq_q  <= sin0_q * uq_q;
      p_sd_q  <= sin0_q * ud_q;
      p_cq_q  <= cos0_q * uq_q;
      eang1_q <= eang0_q;

      ma_q    <= sa[32] ? na[31:0] : sa[31:0];
      mb_q    <= sb[32] ? nb[31:0] : sb[31:0];
      sga_q   <= sa[32];
      sgb_q   <= sb[32];
      eang2_q <= eang1_q;

      alpha3_q <= sat16(sga_q ? -signed'(34'(div_q15one(ma_q)))
                              : signed'(34'(div_q15one(ma_q))));
      beta3_q  <= sat16(sgb_q ? -signed'(34'(div_q15one(mb_q)))
                              : signed'(34'(div_q15one(mb_q))));
      eang3_q  <= eang2_q;

      mt_q     <= tprod[31:0];
      sgt_q    <= beta3_q[15];
      alpha4_q <= alpha3_q;
      eang4_q  <= eang3_q;

      x5_q     <= 20'(t5) - 20'(alpha4_q);
      alpha5_q <= alpha4_q;
      eang5_q  <= eang4_q;

      pa6_q    <= alpha5_q;
      pb6_q    <= sat16(34'(xh));
      eang6_q  <= eang5_q;

      out_q.phase_a    <= pa6_q;
      out_q.phase_b    <= pb6_q;
      out_q.phase_c    <= sat16(-(34'(pa6_q) + 34'(pb6_q)));
      out_q.elec_angle <= eang6_q;
    end
  end

  assign valid_o = valid_q[7];
  assign word_o  = out_q;

endmodule

`default_nettype wire
